>>> src/pnc_pkg.sv
// shared types and constants for the palette nearest colour match block
// no dependencies; imported by pnc_cell and the top level
package pnc_pkg;

   localparam int PALETTE_DEPTH = 256;
   localparam int IDX_W         = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam int CHAN_W        = 8;
   localparam int SLOT_W        = 8;
   localparam int BEST_W        = 8;
   localparam int COUNT_W       = 9;
   localparam int SQ_W          = 2 * CHAN_W;
   localparam int DIST_W        = 18;
   localparam int RGB_W         = 3 * CHAN_W;

   localparam logic [CHAN_W-1:0]  QUANT_MASK     = 8'hF8;
   localparam logic [CHAN_W-1:0]  QUANT_OFFSET   = 8'd4;
   localparam logic [DIST_W-1:0]  START_DISTANCE = 18'd200000;
   localparam logic [COUNT_W-1:0] COUNT_RESET    = 9'd256;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_MATCH = 1'b1;

   // palette write broadcast to every cell
   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] index;
      logic [RGB_W-1:0]  rgb;
   } pnc_load_type;

   // query word travelling down the chain with the running best
   typedef struct packed {
      logic              valid;
      logic [CHAN_W-1:0] qr;
      logic [CHAN_W-1:0] qg;
      logic [CHAN_W-1:0] qb;
      logic [DIST_W-1:0] best_dist;
      logic [IDX_W-1:0]  best_idx;
   } pnc_token_type;

endpackage

>>> src/palette_nearest_colour_match_top.sv
// palette nearest colour match: a row of PALETTE_DEPTH cells, one palette entry each
// a load word is written in the cycle it is accepted and yields no result
// a match word walks the row one cell a cycle; its result leaves the last cell into the
// output register; no new word is taken while a match is in the row or a result waits in the holding slot
// synchronous reset clears the handshake state and sets entry_count to 256;
// palette contents are undefined until loaded; depends on pnc_pkg and pnc_cell
module palette_nearest_colour_match_top
   import pnc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_operation,
   input  logic [SLOT_W-1:0]  req_entry_index,
   input  logic [CHAN_W-1:0]  req_red_in,
   input  logic [CHAN_W-1:0]  req_green_in,
   input  logic [CHAN_W-1:0]  req_blue_in,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [BEST_W-1:0]  rsp_best_index,

   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [COUNT_W-1:0] csr_entry_count
);

   logic [COUNT_W-1:0] entry_count_ff;
   logic               busy_ff, busy_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]   pend_idx_ff, pend_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]   rsp_idx_ff, rsp_idx_in;

   logic               req_accept;
   logic               match_accept;
   logic               out_free;
   pnc_load_type       load;
   pnc_token_type      chain_tok [PALETTE_DEPTH+1];
   pnc_token_type      tail;

   assign req_stall    = busy_ff || pend_valid_ff;
   assign req_accept   = req_valid && !req_stall;
   assign match_accept = req_accept && (req_operation == OP_MATCH);
   assign csr_ready    = 1'b1;

   always_comb begin
      load.en    = req_accept && (req_operation == OP_LOAD);
      load.index = req_entry_index;
      load.rgb   = {req_red_in, req_green_in, req_blue_in};
   end

   // quantised query enters the first cell
   always_comb begin
      chain_tok[0].valid     = match_accept;
      chain_tok[0].qr        = (req_red_in & QUANT_MASK) + QUANT_OFFSET;
      chain_tok[0].qg        = (req_green_in & QUANT_MASK) + QUANT_OFFSET;
      chain_tok[0].qb        = (req_blue_in & QUANT_MASK) + QUANT_OFFSET;
      chain_tok[0].best_dist = START_DISTANCE;
      chain_tok[0].best_idx  = '0;
   end

   for (genvar g = 0; g < PALETTE_DEPTH; g++) begin : g_cell
      pnc_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_index  (IDX_W'(g)),
         .entry_count (entry_count_ff),
         .load        (load),
         .tok_in      (chain_tok[g]),
         .tok_out     (chain_tok[g+1])
      );
   end

   assign tail = chain_tok[PALETTE_DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         entry_count_ff <= csr_entry_count;
      end
   end

   // output register with a one-word holding slot behind it
   always_comb begin
      out_free      = !rsp_valid_ff || !rsp_stall;
      busy_in       = busy_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_idx_in    = rsp_idx_ff;
      if (match_accept) begin
         busy_in = 1'b1;
      end
      if (tail.valid) begin
         busy_in = 1'b0;
      end
      if (pend_valid_ff && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_idx_in    = pend_idx_ff;
         pend_valid_in = 1'b0;
      end else if (tail.valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_idx_in   = tail.best_idx;
      end else if (tail.valid) begin
         pend_valid_in = 1'b1;
         pend_idx_in   = tail.best_idx;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pend_idx_ff <= pend_idx_in;
      rsp_idx_ff  <= rsp_idx_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_best_index = BEST_W'(rsp_idx_ff);

   a_pend_behind_out: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> rsp_valid_ff)
      else $error("holding slot full while output register empty");

   a_tail_while_busy: assert property (@(posedge clock) disable iff (reset)
      tail.valid |-> (busy_ff && !pend_valid_ff))
      else $error("result left the chain with no match in flight");

   a_match_sets_busy: assert property (@(posedge clock) disable iff (reset)
      match_accept |=> busy_ff)
      else $error("accepted match did not occupy the chain");

   a_no_lost_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall && !pend_valid_ff) |=> rsp_valid_ff)
      else $error("stalled result dropped");

endmodule

>>> src/pnc_cell.sv
// one cell of the search chain: holds one palette entry and scores the passing query
// depends on pnc_pkg
module pnc_cell
   import pnc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [IDX_W-1:0]   cell_index,
   input  logic [COUNT_W-1:0] entry_count,
   input  pnc_load_type       load,
   input  pnc_token_type      tok_in,
   output pnc_token_type      tok_out
);

   logic [RGB_W-1:0]  entry_ff;
   pnc_token_type     tok_ff;
   pnc_token_type     tok_in_next;

   logic [CHAN_W-1:0] er, eg, eb;
   logic [CHAN_W-1:0] dr, dg, db;
   logic [SQ_W-1:0]   sr, sg, sb;
   logic [DIST_W-1:0] distance;
   logic              in_range;
   logic              hit;

   always_comb begin
      er = entry_ff[RGB_W-1 -: CHAN_W];
      eg = entry_ff[2*CHAN_W-1 -: CHAN_W];
      eb = entry_ff[CHAN_W-1:0];
      dr = (er >= tok_in.qr) ? (er - tok_in.qr) : (tok_in.qr - er);
      dg = (eg >= tok_in.qg) ? (eg - tok_in.qg) : (tok_in.qg - eg);
      db = (eb >= tok_in.qb) ? (eb - tok_in.qb) : (tok_in.qb - eb);
      sr = SQ_W'(dr) * SQ_W'(dr);
      sg = SQ_W'(dg) * SQ_W'(dg);
      sb = SQ_W'(db) * SQ_W'(db);
      distance = DIST_W'(sr) + DIST_W'(sg) + DIST_W'(sb);
      in_range = COUNT_W'(cell_index) < entry_count;
      // strict compare keeps ties on the lower index
      hit = tok_in.valid && in_range && (distance < tok_in.best_dist);
      tok_in_next = tok_in;
      if (hit) begin
         tok_in_next.best_dist = distance;
         tok_in_next.best_idx  = cell_index;
      end
   end

   always_ff @(posedge clock) begin
      if (load.en && (load.index == SLOT_W'(cell_index))) begin
         entry_ff <= load.rgb;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   assign tok_out = tok_ff;

endmodule
